FILE: hw/rtl/trpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trpr_pkg - shared constants and types
// Widths, status codes and controller types of the triangle rasterizer.
// ----------------------------------------------------------------------------
package trpr_pkg;

    localparam int COORD_INT_BITS   = 12;
    localparam int COORD_FRAC_BITS  = 4;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int COORD_BITS       = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int DUAL_FRAC_BITS   = WEIGHT_FRAC_BITS + COORD_BITS - 2;
    localparam int LAMBDA_BITS      = WEIGHT_FRAC_BITS + 1;
    localparam int SHIFT_BITS       = DUAL_FRAC_BITS - WEIGHT_FRAC_BITS;
    // edge vector component, signed
    localparam int DIFF_BITS        = COORD_BITS + 1;
    // product of a pair of edge components
    localparam int PROD_BITS        = 2 * DIFF_BITS;
    // cross product, signed, and its magnitude
    localparam int CROSS_BITS       = PROD_BITS + 1;
    localparam int DEN_BITS         = 2 * COORD_BITS + 2;
    // numerator scaled by one guard bit beyond the dual fraction
    localparam int DIVIDEND_BITS    = COORD_BITS + DUAL_FRAC_BITS + 1;
    localparam int DIV_CNT_BITS     = $clog2(DIVIDEND_BITS);
    localparam int SAT_EXP          = 34;
    localparam int DUAL_BITS        = 32;
    localparam int RX_BITS          = COORD_BITS + 2;
    localparam int ACC_BITS         = RX_BITS + DUAL_BITS + 2;
    localparam int WEIGHT_BITS      = ACC_BITS - SHIFT_BITS;
    localparam int NUM_DUALS        = 4;
    localparam int IDX_BITS         = $clog2(NUM_DUALS);

    localparam logic [1:0] STATUS_OUTSIDE = 2'd0;
    localparam logic [1:0] STATUS_INSIDE  = 2'd1;
    localparam logic [1:0] STATUS_IDLE    = 2'd2;

    localparam logic MODE_LOAD = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CROSS1,
        S_CROSS2,
        S_CROSS3,
        S_CHECK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MAC,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                capture;
        logic                cross1;
        logic                cross2;
        logic                cross3;
        logic                div_start;
        logic                dual_write;
        logic                mac;
        logic                finish;
        logic                step;
        logic [IDX_BITS-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic cr_zero;
        logic div_done;
    } t_stat;

endpackage
`default_nettype wire

FILE: hw/rtl/trpr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trpr_if - item channels
// Load/step channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface trpr_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic [trpr_pkg::COORD_BITS-1:0]    first_x;
    logic [trpr_pkg::COORD_BITS-1:0]    first_y;
    logic [trpr_pkg::COORD_BITS-1:0]    second_x;
    logic [trpr_pkg::COORD_BITS-1:0]    second_y;
    logic [trpr_pkg::COORD_BITS-1:0]    third_x;
    logic [trpr_pkg::COORD_BITS-1:0]    third_y;

    modport source (output valid, mode, first_x, first_y, second_x, second_y,
                    third_x, third_y, input ready);
    modport sink   (input valid, mode, first_x, first_y, second_x, second_y,
                    third_x, third_y, output ready);
endinterface

interface trpr_out_if;
    logic                               valid;
    logic                               ready;
    logic [trpr_pkg::COORD_INT_BITS-1:0] pixel_x;
    logic [trpr_pkg::COORD_INT_BITS-1:0] pixel_y;
    logic [1:0]                         status;
    logic [trpr_pkg::LAMBDA_BITS-1:0]   lambda_one;
    logic [trpr_pkg::LAMBDA_BITS-1:0]   lambda_two;
    logic                               last;

    modport source (output valid, pixel_x, pixel_y, status, lambda_one, lambda_two,
                    last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, status, lambda_one, lambda_two,
                    last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/trpr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trpr_div - dual vector divider
// Restoring division, one quotient bit per cycle, rounded and saturated.
// ----------------------------------------------------------------------------
module trpr_div (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic [trpr_pkg::COORD_BITS-1:0]        i_mag,
    input  wire logic [trpr_pkg::DEN_BITS-1:0]          i_den,
    input  wire logic                                   i_neg,
    output logic                                        o_done,
    output logic signed [trpr_pkg::DUAL_BITS-1:0]       o_quot
);
    localparam int DB = trpr_pkg::DIVIDEND_BITS;
    localparam int NB = trpr_pkg::DEN_BITS;
    localparam int SE = trpr_pkg::SAT_EXP;

    logic                                r_busy;
    logic                                r_done;
    logic [trpr_pkg::DIV_CNT_BITS-1:0]   r_cnt;
    logic [NB-1:0]                       r_rem;
    logic [DB-1:0]                       r_quo;
    logic [NB-1:0]                       r_den;
    logic                                r_neg;

    logic [NB:0]                         w_trial;
    logic                                w_ge;
    logic [NB:0]                         w_diff;
    logic                                w_sat;
    logic [SE:0]                         w_round;
    logic [SE-1:0]                       w_half;
    logic [SE-1:0]                       w_limit;
    logic [trpr_pkg::DUAL_BITS-1:0]      w_mag;

    always_comb begin
        w_trial = {r_rem, r_quo[DB-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == trpr_pkg::DIV_CNT_BITS'(DB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {i_mag, {(trpr_pkg::DUAL_FRAC_BITS + 1){1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_quo <= {r_quo[DB-2:0], w_ge};
            r_rem <= w_ge ? w_diff[NB-1:0] : w_trial[NB-1:0];
        end
    end

    // round half away from zero, clamp to the signed 32-bit range
    always_comb begin
        w_sat   = |r_quo[DB-1:SE];
        w_round = {1'b0, r_quo[SE-1:0]} + 1'b1;
        w_half  = w_round[SE:1];
        w_limit = r_neg ? SE'(64'h8000_0000) : SE'(64'h7FFF_FFFF);
        if (w_sat || (w_half > w_limit)) begin
            w_mag = w_limit[trpr_pkg::DUAL_BITS-1:0];
        end else begin
            w_mag = w_half[trpr_pkg::DUAL_BITS-1:0];
        end
        o_quot = r_neg ? -$signed(w_mag) : $signed(w_mag);
        o_done = r_done;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/trpr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trpr_dp - rasterizer datapath
// Triangle setup registers, dual vectors, weight accumulators and result.
// ----------------------------------------------------------------------------
module trpr_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire trpr_pkg::t_cmd                         i_cmd,
    output trpr_pkg::t_stat                             o_stat,
    input  wire logic [trpr_pkg::COORD_BITS-1:0]        i_ax,
    input  wire logic [trpr_pkg::COORD_BITS-1:0]        i_ay,
    input  wire logic [trpr_pkg::COORD_BITS-1:0]        i_bx,
    input  wire logic [trpr_pkg::COORD_BITS-1:0]        i_by,
    input  wire logic [trpr_pkg::COORD_BITS-1:0]        i_cx,
    input  wire logic [trpr_pkg::COORD_BITS-1:0]        i_cy,
    output logic [trpr_pkg::COORD_INT_BITS-1:0]         o_pixel_x,
    output logic [trpr_pkg::COORD_INT_BITS-1:0]         o_pixel_y,
    output logic [1:0]                                  o_status,
    output logic [trpr_pkg::LAMBDA_BITS-1:0]            o_lambda_one,
    output logic [trpr_pkg::LAMBDA_BITS-1:0]            o_lambda_two,
    output logic                                        o_last
);
    localparam int CB = trpr_pkg::COORD_BITS;
    localparam int IB = trpr_pkg::COORD_INT_BITS;
    localparam int FB = trpr_pkg::COORD_FRAC_BITS;
    localparam int AB = trpr_pkg::ACC_BITS;
    localparam int WB = trpr_pkg::WEIGHT_BITS;

    logic [CB-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [trpr_pkg::PROD_BITS-1:0]  r_p1, r_p2;
    logic signed [trpr_pkg::CROSS_BITS-1:0] r_cr;
    logic [IB-1:0] r_start_x, r_cur_x, r_cur_y;
    logic [CB-1:0] r_end_x, r_end_y;
    logic signed [trpr_pkg::DUAL_BITS-1:0] r_q [trpr_pkg::NUM_DUALS];
    logic signed [AB-1:0] r_acc1, r_acc2, r_row1, r_row2;
    logic r_active;

    logic signed [trpr_pkg::DIFF_BITS-1:0] w_k1x, w_k1y, w_k2x, w_k2y, w_num;
    logic [trpr_pkg::DIFF_BITS-1:0]        w_num_abs;
    logic [trpr_pkg::CROSS_BITS-1:0]       w_cr_abs;
    logic                                  w_div_done;
    logic signed [trpr_pkg::DUAL_BITS-1:0] w_quot;
    logic [CB-1:0] w_minx, w_miny, w_maxx, w_maxy;
    logic signed [trpr_pkg::RX_BITS-1:0]   w_rx0, w_ry0, w_mac_a;
    logic signed [AB-1:0] w_prod, w_mac_sum, w_dx1, w_dx2, w_dy1, w_dy2;
    logic signed [WB-1:0] w_l1, w_l2;
    logic signed [WB:0]   w_lsum;
    logic                 w_inside;
    logic [IB:0]          w_nx, w_ny;
    logic                 w_more_x, w_more_y;

    always_comb begin
        w_k1x = $signed({1'b0, r_bx}) - $signed({1'b0, r_ax});
        w_k1y = $signed({1'b0, r_by}) - $signed({1'b0, r_ay});
        w_k2x = $signed({1'b0, r_cx}) - $signed({1'b0, r_ax});
        w_k2y = $signed({1'b0, r_cy}) - $signed({1'b0, r_ay});
        case (i_cmd.idx)
            2'd0:    w_num = w_k2y;
            2'd1:    w_num = -w_k2x;
            2'd2:    w_num = -w_k1y;
            default: w_num = w_k1x;
        endcase
        w_num_abs = w_num[trpr_pkg::DIFF_BITS-1] ? -w_num : w_num;
        w_cr_abs  = r_cr[trpr_pkg::CROSS_BITS-1] ? -r_cr : r_cr;
        w_minx = (r_ax < r_bx) ? r_ax : r_bx;
        w_minx = (w_minx < r_cx) ? w_minx : r_cx;
        w_miny = (r_ay < r_by) ? r_ay : r_by;
        w_miny = (w_miny < r_cy) ? w_miny : r_cy;
        w_maxx = (r_ax > r_bx) ? r_ax : r_bx;
        w_maxx = (w_maxx > r_cx) ? w_maxx : r_cx;
        w_maxy = (r_ay > r_by) ? r_ay : r_by;
        w_maxy = (w_maxy > r_cy) ? w_maxy : r_cy;
    end

    trpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_mag   (w_num_abs[CB-1:0]),
        .i_den   (w_cr_abs[trpr_pkg::DEN_BITS-1:0]),
        .i_neg   (w_num[trpr_pkg::DIFF_BITS-1] ^ r_cr[trpr_pkg::CROSS_BITS-1]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // start position relative to the first vertex, one multiply per cycle
    always_comb begin
        w_rx0     = $signed({2'b00, r_start_x, {FB{1'b0}}}) - $signed({2'b00, r_ax});
        w_ry0     = $signed({2'b00, r_cur_y, {FB{1'b0}}}) - $signed({2'b00, r_ay});
        w_mac_a   = i_cmd.idx[0] ? w_ry0 : w_rx0;
        w_prod    = AB'(w_mac_a * r_q[i_cmd.idx]);
        w_mac_sum = w_prod + (i_cmd.idx[0] ? (i_cmd.idx[1] ? r_acc2 : r_acc1) : AB'(0));
    end

    // weights of the current position and the walk increments
    always_comb begin
        w_l1     = WB'(r_acc1 >>> trpr_pkg::SHIFT_BITS);
        w_l2     = WB'(r_acc2 >>> trpr_pkg::SHIFT_BITS);
        w_lsum   = (WB + 1)'(w_l1) + (WB + 1)'(w_l2);
        w_inside = !w_l1[WB-1] && !w_l2[WB-1]
                   && (w_lsum <= $signed((WB + 1)'(1) <<< trpr_pkg::WEIGHT_FRAC_BITS));
        w_dx1    = AB'(r_q[0]) <<< FB;
        w_dy1    = AB'(r_q[1]) <<< FB;
        w_dx2    = AB'(r_q[2]) <<< FB;
        w_dy2    = AB'(r_q[3]) <<< FB;
        w_nx     = {1'b0, r_cur_x} + 1'b1;
        w_ny     = {1'b0, r_cur_y} + 1'b1;
        w_more_x = {w_nx, {FB{1'b0}}} < {1'b0, r_end_x};
        w_more_y = {w_ny, {FB{1'b0}}} < {1'b0, r_end_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.capture) begin
            r_active <= 1'b0;
        end else if (i_cmd.finish) begin
            r_active <= ({r_start_x, {FB{1'b0}}} < r_end_x)
                        && ({r_cur_y, {FB{1'b0}}} < r_end_y);
        end else if (i_cmd.step && r_active && !w_more_x && !w_more_y) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ax <= i_ax;
            r_ay <= i_ay;
            r_bx <= i_bx;
            r_by <= i_by;
            r_cx <= i_cx;
            r_cy <= i_cy;
        end
        if (i_cmd.cross1) begin
            r_p1      <= w_k1x * w_k2y;
            r_start_x <= w_minx[CB-1:FB];
            r_cur_x   <= w_minx[CB-1:FB];
            r_cur_y   <= w_miny[CB-1:FB];
            r_end_x   <= w_maxx;
            r_end_y   <= w_maxy;
        end
        if (i_cmd.cross2) begin
            r_p2 <= w_k1y * w_k2x;
        end
        if (i_cmd.cross3) begin
            r_cr <= (trpr_pkg::CROSS_BITS)'(r_p1) - (trpr_pkg::CROSS_BITS)'(r_p2);
        end
        if (i_cmd.dual_write) begin
            r_q[i_cmd.idx] <= w_quot;
        end
        if (i_cmd.mac) begin
            if (i_cmd.idx[1]) begin
                r_acc2 <= w_mac_sum;
                r_row2 <= w_mac_sum;
            end else begin
                r_acc1 <= w_mac_sum;
                r_row1 <= w_mac_sum;
            end
        end
        if (i_cmd.step) begin
            if (r_active) begin
                o_pixel_x    <= r_cur_x;
                o_pixel_y    <= r_cur_y;
                o_status     <= w_inside ? trpr_pkg::STATUS_INSIDE : trpr_pkg::STATUS_OUTSIDE;
                o_lambda_one <= w_inside ? w_l1[trpr_pkg::LAMBDA_BITS-1:0] : '0;
                o_lambda_two <= w_inside ? w_l2[trpr_pkg::LAMBDA_BITS-1:0] : '0;
                o_last       <= !w_more_x && !w_more_y;
                if (w_more_x) begin
                    r_cur_x <= w_nx[IB-1:0];
                    r_acc1  <= r_acc1 + w_dx1;
                    r_acc2  <= r_acc2 + w_dx2;
                end else begin
                    r_cur_x <= r_start_x;
                    r_row1  <= r_row1 + w_dy1;
                    r_row2  <= r_row2 + w_dy2;
                    r_acc1  <= r_row1 + w_dy1;
                    r_acc2  <= r_row2 + w_dy2;
                    if (w_more_y) begin
                        r_cur_y <= w_ny[IB-1:0];
                    end
                end
            end else begin
                o_pixel_x    <= '0;
                o_pixel_y    <= '0;
                o_status     <= trpr_pkg::STATUS_IDLE;
                o_lambda_one <= '0;
                o_lambda_two <= '0;
                o_last       <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.cr_zero  = (r_cr == '0);
        o_stat.div_done = w_div_done;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/trpr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trpr_ctrl - rasterizer controller
// Sequences triangle setup and issues step commands; owns result valid.
// ----------------------------------------------------------------------------
module trpr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_mode,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire trpr_pkg::t_stat    i_stat,
    output trpr_pkg::t_cmd          o_cmd
);
    trpr_pkg::t_state                 r_state, n_state;
    logic [trpr_pkg::IDX_BITS-1:0]    r_idx, n_idx;
    logic                             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= trpr_pkg::S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        o_in_ready  = 1'b0;
        case (r_state)
            trpr_pkg::S_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                if (i_in_valid && o_in_ready) begin
                    if (i_in_mode == trpr_pkg::MODE_LOAD) begin
                        o_cmd.capture = 1'b1;
                        n_state       = trpr_pkg::S_CROSS1;
                    end else begin
                        o_cmd.step  = 1'b1;
                        n_out_valid = 1'b1;
                    end
                end
            end
            trpr_pkg::S_CROSS1: begin
                o_cmd.cross1 = 1'b1;
                n_state      = trpr_pkg::S_CROSS2;
            end
            trpr_pkg::S_CROSS2: begin
                o_cmd.cross2 = 1'b1;
                n_state      = trpr_pkg::S_CROSS3;
            end
            trpr_pkg::S_CROSS3: begin
                o_cmd.cross3 = 1'b1;
                n_state      = trpr_pkg::S_CHECK;
            end
            trpr_pkg::S_CHECK: begin
                n_idx   = '0;
                n_state = i_stat.cr_zero ? trpr_pkg::S_IDLE : trpr_pkg::S_DIV_GO;
            end
            trpr_pkg::S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = trpr_pkg::S_DIV_WAIT;
            end
            trpr_pkg::S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.dual_write = 1'b1;
                    n_idx            = r_idx + 1'b1;
                    n_state          = (r_idx == '1) ? trpr_pkg::S_MAC : trpr_pkg::S_DIV_GO;
                end
            end
            trpr_pkg::S_MAC: begin
                o_cmd.mac = 1'b1;
                n_idx     = r_idx + 1'b1;
                if (r_idx == '1) begin
                    n_state = trpr_pkg::S_FINISH;
                end
            end
            trpr_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = trpr_pkg::S_IDLE;
            end
            default: begin
                n_state = trpr_pkg::S_IDLE;
            end
        endcase
        o_out_valid = r_out_valid;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/triangle_pixel_rasterizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_pixel_rasterizer - barycentric triangle rasterizer
// Walks the bounding box of a triangle and reports barycentric weights.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries load items (mode 0: three vertices, unsigned 12.4) and step
//   items (mode 1). o_out carries one result item per step item: the visited
//   pixel, inside/outside/idle status, Q1.16 weights and a last flag.
//   A load produces no result. It computes the cross product, four dual
//   vector components through one shared bit-serial divider and the start
//   weights with one multiplier; no new item is taken until the setup ends.
//   A degenerate triangle ends the load after the cross product check and
//   leaves the block idle; a triangle whose box holds no position runs the
//   full setup and then leaves the block idle. In a step the weights are
//   advanced by adding the dual vectors, so the result register is valid
//   the cycle after accept, and a new step is taken every cycle while the
//   receiver keeps o_out.ready high.
//   When the receiver stalls, the result register holds its item and i_in
//   is taken again in the same cycle the stalled item leaves.
//   Reset (i_rst_n low at a clock edge) drops any traversal; steps then
//   report idle until a triangle is loaded.
// ----------------------------------------------------------------------------
module triangle_pixel_rasterizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    trpr_in_if.sink         i_in,
    trpr_out_if.source      o_out
);
    trpr_pkg::t_cmd  w_cmd;
    trpr_pkg::t_stat w_stat;

    // sequence setup and own the handshakes
    trpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // setup arithmetic, walk state and the result register
    trpr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_ax         (i_in.first_x),
        .i_ay         (i_in.first_y),
        .i_bx         (i_in.second_x),
        .i_by         (i_in.second_y),
        .i_cx         (i_in.third_x),
        .i_cy         (i_in.third_y),
        .o_pixel_x    (o_out.pixel_x),
        .o_pixel_y    (o_out.pixel_y),
        .o_status     (o_out.status),
        .o_lambda_one (o_out.lambda_one),
        .o_lambda_two (o_out.lambda_two),
        .o_last       (o_out.last)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/trpr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trpr_checker - port checks
// Result consistency checks on the rasterizer's ports.
// ----------------------------------------------------------------------------
module trpr_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic [1:0]                          i_status,
    input wire logic [trpr_pkg::COORD_INT_BITS-1:0] i_pixel_x,
    input wire logic [trpr_pkg::LAMBDA_BITS-1:0]    i_lambda_one,
    input wire logic [trpr_pkg::LAMBDA_BITS-1:0]    i_lambda_two,
    input wire logic                                i_last
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == trpr_pkg::STATUS_IDLE)
        |-> (i_pixel_x == '0) && !i_last)
        else $error("idle result carries data");

    a_weights_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != trpr_pkg::STATUS_INSIDE)
        |-> (i_lambda_one == '0) && (i_lambda_two == '0))
        else $error("weights set outside triangle");

    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == trpr_pkg::STATUS_INSIDE)
        |-> ({1'b0, i_lambda_one} + {1'b0, i_lambda_two})
            <= ((trpr_pkg::LAMBDA_BITS + 1)'(1) << trpr_pkg::WEIGHT_FRAC_BITS))
        else $error("weights sum above one");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status != 2'd3))
        else $error("bad status code");
endmodule

bind triangle_pixel_rasterizer trpr_checker u_trpr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_pixel_x    (o_out.pixel_x),
    .i_lambda_one (o_out.lambda_one),
    .i_lambda_two (o_out.lambda_two),
    .i_last       (o_out.last)
);
`default_nettype wire
